[hw/rtl/osm_pkg.sv]
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants for the 1-Wire transaction master
// Transfer payload structs, opcodes, status codes, command bytes and bus timing constants.
// ----------------------------------------------------------------------------
package osm_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        use_rom;
        logic [63:0] rom_code;
        logic        line_high;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic [3:0] byte_index;
        logic       last_byte;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CONV = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NODEV  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

    localparam logic [9:0] RESET_LOW_US   = 10'd480;
    localparam logic [9:0] PRESENCE_US    = 10'd549;
    localparam logic [9:0] RESET_END_US   = 10'd959;
    localparam logic [9:0] SLOT_END_US    = 10'd69;
    localparam logic [9:0] READ_SAMPLE_US = 10'd14;
    localparam logic [9:0] WRITE1_LOW_US  = 10'd6;
    localparam logic [9:0] WRITE0_LOW_US  = 10'd60;
    localparam logic [9:0] READ_LOW_US    = 10'd6;

    localparam logic [3:0] SKIP_SEQ_BYTES  = 4'd2;
    localparam logic [3:0] MATCH_SEQ_BYTES = 4'd10;

endpackage

[hw/rtl/osm_core.sv]
// ----------------------------------------------------------------------------
// osm_core: transaction sequencer state and per-item update
// Holds the bus state and computes next state and result for one item.
// ----------------------------------------------------------------------------
module osm_core #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  osm_pkg::t_in_item  i_item,
    output osm_pkg::t_out_item o_res
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_RESET = 5'b00010,
        PH_NODEV = 5'b00100,
        PH_WRITE = 5'b01000,
        PH_READ  = 5'b10000
    } t_phase;

    localparam logic [4:0] LAST_COUNT = 5'(SCRATCH_BYTES);

    t_phase      r_phase, n_phase;
    logic [9:0]  r_timer, n_timer;
    logic [63:0] r_rom, n_rom;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic [3:0]  r_tx_count, n_tx_count;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_rx_byte, n_rx_byte;
    logic [3:0]  r_rx_count, n_rx_count;
    logic [1:0]  r_mode, n_mode;

    function automatic logic [7:0] seq_byte(input logic [3:0] k, input logic [1:0] mode,
                                            input logic [63:0] rom);
        logic [2:0] idx;
        idx = 3'(k - 4'd1);
        if (k == 4'd0) begin
            return mode[1] ? osm_pkg::CMD_MATCH_ROM : osm_pkg::CMD_SKIP_ROM;
        end else if (mode[1] && k <= 4'd8) begin
            return rom[{idx, 3'b000} +: 8];
        end else begin
            return mode[0] ? osm_pkg::CMD_READ_PAD : osm_pkg::CMD_CONVERT;
        end
    endfunction

    logic nodev;
    logic is_cmd;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_rom      = r_rom;
        n_tx_byte  = r_tx_byte;
        n_tx_count = r_tx_count;
        n_bit      = r_bit;
        n_rx_byte  = r_rx_byte;
        n_rx_count = r_rx_count;
        n_mode     = r_mode;
        o_res      = '0;
        nodev      = (r_phase == PH_NODEV) ||
                     (r_phase == PH_RESET && r_timer == osm_pkg::PRESENCE_US &&
                      i_item.line_high);
        is_cmd     = (i_item.opcode == osm_pkg::OP_CONV) ||
                     (i_item.opcode == osm_pkg::OP_READ);

        if (is_cmd) begin
            if (r_phase != PH_IDLE) begin
                o_res.status = osm_pkg::ST_REJECT;
            end else begin
                n_mode     = {i_item.use_rom, i_item.opcode == osm_pkg::OP_READ};
                n_rom      = i_item.rom_code;
                n_phase    = PH_RESET;
                n_timer    = '0;
                n_tx_byte  = '0;
                n_tx_count = '0;
                n_bit      = '0;
                n_rx_byte  = '0;
                n_rx_count = '0;
            end
        end else if (i_item.opcode == osm_pkg::OP_TICK && r_phase != PH_IDLE) begin
            unique case (r_phase)
                PH_RESET, PH_NODEV: begin
                    if (nodev) begin
                        n_phase = PH_NODEV;
                    end
                    if (r_timer >= osm_pkg::RESET_END_US) begin
                        n_timer = '0;
                        if (nodev) begin
                            n_phase         = PH_IDLE;
                            o_res.done_res  = 1'b1;
                            o_res.status    = osm_pkg::ST_NODEV;
                        end else begin
                            n_phase    = PH_WRITE;
                            n_tx_count = '0;
                            n_bit      = '0;
                            n_tx_byte  = seq_byte(4'd0, r_mode, r_rom);
                        end
                    end else begin
                        n_timer = r_timer + 10'd1;
                    end
                end
                PH_WRITE: begin
                    if (r_timer >= osm_pkg::SLOT_END_US) begin
                        n_timer = '0;
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1;
                        end else begin
                            n_bit      = '0;
                            n_tx_count = r_tx_count + 4'd1;
                            if (n_tx_count >= (r_mode[1] ? osm_pkg::MATCH_SEQ_BYTES
                                                         : osm_pkg::SKIP_SEQ_BYTES)) begin
                                if (r_mode[0]) begin
                                    n_phase    = PH_READ;
                                    n_rx_byte  = '0;
                                    n_rx_count = '0;
                                end else begin
                                    n_phase        = PH_IDLE;
                                    o_res.done_res = 1'b1;
                                end
                            end else begin
                                n_tx_byte = seq_byte(n_tx_count, r_mode, r_rom);
                            end
                        end
                    end else begin
                        n_timer = r_timer + 10'd1;
                    end
                end
                PH_READ: begin
                    if (r_timer == osm_pkg::READ_SAMPLE_US && i_item.line_high) begin
                        n_rx_byte[r_bit] = 1'b1;
                    end
                    if (r_timer >= osm_pkg::SLOT_END_US) begin
                        n_timer = '0;
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1;
                        end else begin
                            n_bit            = '0;
                            o_res.byte_valid = 1'b1;
                            o_res.data_byte  = n_rx_byte;
                            o_res.byte_index = r_rx_count;
                            if ({1'b0, r_rx_count} + 5'd1 >= LAST_COUNT) begin
                                o_res.last_byte = 1'b1;
                                o_res.done_res  = 1'b1;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_rx_count = r_rx_count + 4'd1;
                            end
                            n_rx_byte = '0;
                        end
                    end else begin
                        n_timer = r_timer + 10'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        unique case (n_phase)
            PH_RESET, PH_NODEV: o_res.drive_low = n_timer < osm_pkg::RESET_LOW_US;
            PH_WRITE: o_res.drive_low = n_timer < (n_tx_byte[n_bit] ? osm_pkg::WRITE1_LOW_US
                                                                    : osm_pkg::WRITE0_LOW_US);
            PH_READ: o_res.drive_low = n_timer < osm_pkg::READ_LOW_US;
            default: o_res.drive_low = 1'b0;
        endcase
        o_res.busy_res = n_phase != PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_rom      <= '0;
            r_tx_byte  <= '0;
            r_tx_count <= '0;
            r_bit      <= '0;
            r_rx_byte  <= '0;
            r_rx_count <= '0;
            r_mode     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_rom      <= n_rom;
            r_tx_byte  <= n_tx_byte;
            r_tx_count <= n_tx_count;
            r_bit      <= n_bit;
            r_rx_byte  <= n_rx_byte;
            r_rx_count <= n_rx_count;
            r_mode     <= n_mode;
        end
    end

endmodule

[hw/rtl/onewire_sensor_transaction_master_top.sv]
// ----------------------------------------------------------------------------
// onewire_sensor_transaction_master_top: 1-Wire sensor transaction master
// Input register, sequencer and result register with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one item per
//   microsecond tick or command; ticks carry the sampled bus level.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   result per item, in order: drive level for the coming microsecond, busy,
//   received scratchpad bytes, done and status.
//   Path: an item passes the input register, then the result register, where
//   its result is held until it transfers on the output channel.
//   Throughput: one item per cycle unless the output stalls; the sequencer
//   updates its state once per item, input register to result register.
//   Reset: the bus is released, the sequencer is idle and both registers
//   are empty.
//   Stall: while a result waits on i_out_ready, one more item is held in the
//   input register; after that o_in_ready drops until the result transfers.
// ----------------------------------------------------------------------------
module onewire_sensor_transaction_master_top #(
    parameter int SCRATCH_BYTES = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  osm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output osm_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    osm_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    osm_pkg::t_out_item r_out_data;
    osm_pkg::t_out_item core_res;
    logic               advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    osm_core #(
        .SCRATCH_BYTES(SCRATCH_BYTES)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (advance),
        .i_item (r_in_data),
        .o_res  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= core_res;
        end
    end

endmodule

[hw/rtl/osm_checker.sv]
// ----------------------------------------------------------------------------
// osm_checker: port-level checks for the 1-Wire transaction master
// Result consistency and output channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module osm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input osm_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
        o_out_data.data_byte == 8'd0 && o_out_data.byte_index == 4'd0 &&
        !o_out_data.last_byte)
        else $error("byte fields set without a byte");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_byte |->
        o_out_data.byte_valid && o_out_data.done_res)
        else $error("last byte without done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res &&
        !o_out_data.drive_low)
        else $error("done while still busy");

    a_nodev_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == osm_pkg::ST_NODEV |-> o_out_data.done_res)
        else $error("no-device status without done");

endmodule

bind onewire_sensor_transaction_master_top osm_checker u_osm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
